FILE: hdl/vd_pkg.sv
// Shared types and constants for the vector distance block.
// No dependencies; every other file depends on this package.
`default_nettype none

package vd_pkg;

	// accumulator and square-root widths
	localparam int ACC_W      = 40;
	localparam int ROOT_W     = ACC_W + 1;
	localparam int SQ_W       = ACC_W / 2;
	localparam int ROOT_STEPS = ACC_W / 2;

	localparam logic [ACC_W-1:0] ACC_MAX  = {ACC_W{1'b1}};
	localparam logic [ACC_W-1:0] SQ_LIMIT = ACC_W'({SQ_W{1'b1}});

	// metric register codes; the unused code acts as Euclidean
	localparam int METRIC_W = 2;
	localparam logic [METRIC_W-1:0] METRIC_L1    = 2'd0;
	localparam logic [METRIC_W-1:0] METRIC_L2    = 2'd1;
	localparam logic [METRIC_W-1:0] METRIC_L2SQ  = 2'd2;
	localparam logic [METRIC_W-1:0] METRIC_RESET = METRIC_L2;

	// one slot of the square-root cell chain
	typedef struct packed {
		logic              valid;
		logic              bypass;
		logic [ACC_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} cell_t;

endpackage

`default_nettype wire

FILE: hdl/vd_if.sv
// Valid/ready channel interfaces for the vector distance block.
// Depends on vd_pkg for the result and metric widths.
`default_nettype none

// coordinate pair input channel
interface vd_coord_if #(parameter int COORD_BITS = 16);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] a_coord;
	logic signed [COORD_BITS-1:0] b_coord;
	logic                         last_coord;

	modport source (output valid, output a_coord, output b_coord, output last_coord,
		input ready);
	modport sink (input valid, input a_coord, input b_coord, input last_coord,
		output ready);
endinterface

// distance result channel
interface vd_result_if;
	logic                       valid;
	logic                       ready;
	logic [vd_pkg::ACC_W-1:0]   distance;

	modport source (output valid, output distance, input ready);
	modport sink (input valid, input distance, output ready);
endinterface

// metric register write channel
interface vd_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [vd_pkg::METRIC_W-1:0]  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/vector_distance_l1_l2_top.sv
// A last coordinate's distance passes through stage 1, stage 2, the root cells and the output register.
// Throughput: one coordinate pair per cycle; the accumulator takes one term a cycle
// and the square root runs as a chain of twenty cells, one step per cell.
// A stalled result freezes the whole pipeline until it is taken.
// Reset: metric is Euclidean, accumulator zero, pipeline and output empty.
// Depends on vd_pkg, vd_if, vd_accum and vd_root_cell.
`default_nettype none

module vector_distance_l1_l2_top (
	input  wire logic clk,
	input  wire logic arst_n,
	vd_coord_if.sink  coords,
	vd_result_if.source result,
	vd_cfg_if.sink    cfg
);
	import vd_pkg::*;

	logic [METRIC_W-1:0] metric_q;
	logic                en;
	logic                out_valid_q;
	logic [ACC_W-1:0]    distance_q;
	cell_t               chain [ROOT_STEPS+1];

	// metric register, writable at any time
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			metric_q <= METRIC_RESET;
		end else if (cfg.valid) begin
			metric_q <= cfg.data;
		end
	end

	// pipeline advances whenever the output slot is free or being drained
	assign en = !out_valid_q || result.ready;

	vd_accum u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.metric (metric_q),
		.coords (coords),
		.cell_o (chain[0])
	);

	// square-root cell chain, most significant step first
	for (genvar i = 0; i < ROOT_STEPS; i++) begin : g_cell
		vd_root_cell #(.STEP(ROOT_STEPS - 1 - i)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.cell_i (chain[i]),
			.cell_o (chain[i+1])
		);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= chain[ROOT_STEPS].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			distance_q <= chain[ROOT_STEPS].bypass ? chain[ROOT_STEPS].rem
				: chain[ROOT_STEPS].root[ACC_W-1:0];
		end
	end

	assign result.valid    = out_valid_q;
	assign result.distance = distance_q;

	// a stall freezes the end of the chain
	a_stall_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(chain[ROOT_STEPS].valid))
		else $error("root chain moved during output stall");

	// a finished root fits in half the accumulator width
	a_root_bound: assert property (@(posedge clk) disable iff (!arst_n)
		chain[ROOT_STEPS].valid && !chain[ROOT_STEPS].bypass
		|-> (chain[ROOT_STEPS].root >> SQ_W) == '0)
		else $error("square root out of range");

	// a new result comes only from the end of the chain
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(chain[ROOT_STEPS].valid))
		else $error("result without chain entry");

	// no input transfer while the output slot is blocked
	a_block_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !result.ready |=> $stable(chain[0]))
		else $error("pipeline front changed during stall");

endmodule

`default_nettype wire

FILE: hdl/vd_accum.sv
// Front end: per-coordinate term (abs or square) and saturating accumulator.
// Depends on vd_pkg and vd_coord_if; feeds the first cell of the root chain.
`default_nettype none

module vd_accum (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        en,
	input  wire logic [vd_pkg::METRIC_W-1:0] metric,
	vd_coord_if.sink                         coords,
	output vd_pkg::cell_t                    cell_o
);
	import vd_pkg::*;

	localparam int CW = $bits(coords.a_coord);

	logic signed [CW:0]      diff;
	logic [CW:0]             mag;
	logic [ACC_W-1:0]        mag_w;
	logic [2*SQ_W-1:0]       sq;
	logic [ACC_W-1:0]        term;
	logic                    is_l1;
	logic                    is_l2sq;

	logic                    valid_s1;
	logic                    last_s1;
	logic                    root_s1;
	logic [ACC_W-1:0]        term_s1;

	logic [ACC_W-1:0]        acc_q;
	logic [ACC_W:0]          sum_wide;
	logic [ACC_W-1:0]        sum;
	cell_t                   cell_s2;

	assign coords.ready = en;

	// difference magnitude and the term for the metric in force
	always_comb begin
		diff    = {coords.a_coord[CW-1], coords.a_coord} - {coords.b_coord[CW-1], coords.b_coord};
		mag     = diff[CW] ? (CW+1)'(-diff) : (CW+1)'(diff);
		mag_w   = ACC_W'(mag);
		sq      = mag_w[SQ_W-1:0] * mag_w[SQ_W-1:0];
		is_l1   = (metric == METRIC_L1);
		is_l2sq = (metric == METRIC_L2SQ);
		if (is_l1) begin
			term = mag_w;
		end else if (mag_w > SQ_LIMIT) begin
			term = ACC_MAX;
		end else begin
			term = ACC_W'(sq);
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= coords.valid;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (en) begin
			term_s1 <= term;
			last_s1 <= coords.last_coord;
			root_s1 <= !is_l1 && !is_l2sq;
		end
	end

	// saturating add
	always_comb begin
		sum_wide = {1'b0, acc_q} + {1'b0, term_s1};
		sum      = (sum_wide >= {1'b0, ACC_MAX}) ? ACC_MAX : sum_wide[ACC_W-1:0];
	end

	// stage 2: accumulator and result launch into the chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			cell_s2 <= '0;
		end else if (en) begin
			cell_s2.valid  <= valid_s1 && last_s1;
			cell_s2.rem    <= sum;
			cell_s2.root   <= '0;
			cell_s2.bypass <= !root_s1;
			if (valid_s1) begin
				acc_q <= last_s1 ? '0 : sum;
			end
		end
	end

	assign cell_o = cell_s2;

endmodule

`default_nettype wire

FILE: hdl/vd_root_cell.sv
// One cell of the integer square-root chain: a single digit-pair step.
// Depends on vd_pkg; STEP selects the trial bit position of this cell.
`default_nettype none

module vd_root_cell #(
	parameter int STEP = 0
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     en,
	input  vd_pkg::cell_t cell_i,
	output vd_pkg::cell_t cell_o
);
	import vd_pkg::*;

	localparam logic [ROOT_W-1:0] TRIAL_BIT = ROOT_W'(1) << (2 * STEP);

	logic [ROOT_W-1:0] trial;
	cell_t             nxt;
	cell_t             cell_q;

	// compare-subtract step; results for other metrics pass unchanged
	always_comb begin
		trial = cell_i.root + TRIAL_BIT;
		nxt   = cell_i;
		if (!cell_i.bypass) begin
			if ({1'b0, cell_i.rem} >= trial) begin
				nxt.rem  = cell_i.rem - trial[ACC_W-1:0];
				nxt.root = (cell_i.root >> 1) + TRIAL_BIT;
			end else begin
				nxt.root = cell_i.root >> 1;
			end
		end
	end

	// cell register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_q <= '0;
		end else if (en) begin
			cell_q <= nxt;
		end
	end

	assign cell_o = cell_q;

endmodule

`default_nettype wire
